@@ src/pps_pkg.sv @@
// Shared constants, types and field layout for the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package pps_pkg;

	// Sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 8;
	localparam int LEVELS      = 5;

	localparam int PID_W  = PID_BITS;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

	// Command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// Port field layout
	localparam int PRIO_PORT_W = 3;
	localparam int PID_PORT_W  = 8;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 16;

	// Input tdata: priority_req [2:0], pid [10:3]
	localparam int S_PRIO_LSB = 0;
	localparam int S_PID_LSB  = S_PRIO_LSB + PRIO_PORT_W;

	// Command kinds carried on s_axis_tuser
	localparam logic MODE_ADMIT   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_IDLE_REL = 2'd2
	} status_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic             release_cpu;
		logic [LVL_W-1:0] level;
		logic [PID_W-1:0] pid;
	} cmd_t;

	// One result beat
	typedef struct packed {
		status_t                status;
		logic [PRIO_PORT_W-1:0] running_priority;
		logic [PID_PORT_W-1:0]  running_pid;
		logic                   cpu_busy;
	} res_t;

endpackage

`default_nettype wire

@@ src/preemptive_priority_scheduler_unit.sv @@
// Top level of the preemptive priority scheduler: front end, command queue, engine.
// Depends on pps_pkg, pps_front, pps_cmd_fifo and pps_engine.
//
//  Channel  | Dir | Beat contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tuser: mode; tdata: priority_req, pid
//  m_axis   | out | tdata: cpu_busy, running_pid, running_priority, status
//
//  Admit is decided directly in the idle state; release with a queued process also
//  passes the fetch state, set by the registered read of the ready-queue memory.
//  A beat is registered in the front stage before the command queue.
//  Reset clears runner state and all queue pointers at once; no clearing pass.
//  A stalled m_axis holds the engine; the front keeps taking beats until the
//  two-entry command queue and the front stage are full.
`default_nettype none

module preemptive_priority_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [2:0] priority_req, [10:3] pid, [15:11] zero
	input  logic [pps_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] mode
	input  logic [0:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] cpu_busy, [8:1] running_pid, [11:9] running_priority, [13:12] status,
	// [15:14] zero
	output logic [pps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import pps_pkg::*;

	logic fe_valid, fe_ready;
	cmd_t fe_cmd;
	logic q_valid, q_ready;
	cmd_t q_cmd;
	res_t res;

	pps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (fe_valid),
		.cmd_ready     (fe_ready),
		.cmd           (fe_cmd)
	);

	pps_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_cmd    (fe_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	pps_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Result beat packing
	assign m_axis_tdata = {2'b00, res};

endmodule

`default_nettype wire

@@ src/pps_front.sv @@
// Front end: accepts input beats, decodes the command kind and saturates the priority.
// Depends on pps_pkg.
`default_nettype none

module pps_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic [0:0]                     s_axis_tuser,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output pps_pkg::cmd_t                  cmd
);
	import pps_pkg::*;

	logic                   v_s1;
	cmd_t                   cmd_s1;
	cmd_t                   cls;
	logic [PRIO_PORT_W-1:0] prio_in;
	logic                   take;

	// Classify: priorities above the top level saturate
	always_comb begin
		prio_in         = s_axis_tdata[S_PRIO_LSB +: PRIO_PORT_W];
		cls.release_cpu = (s_axis_tuser[0] == MODE_RELEASE);
		cls.pid         = PID_W'(s_axis_tdata[S_PID_LSB +: PID_PORT_W]);
		if (int'(prio_in) > LEVELS - 1) begin
			cls.level = LVL_W'(LEVELS - 1);
		end else begin
			cls.level = LVL_W'(prio_in);
		end
	end

	assign s_axis_tready = !v_s1 || cmd_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

@@ src/pps_cmd_fifo.sv @@
// Short command queue decoupling the front end from the scheduling engine.
// Depends on pps_pkg.
`default_nettype none

module pps_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pps_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output pps_pkg::cmd_t out_cmd
);
	import pps_pkg::*;

	cmd_t                buf_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign in_ready  = (cnt_q != CQ_CNT_W'(CQ_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = buf_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

@@ src/pps_engine.sv @@
// Back end: runner state, per-level ready queues in one memory, result register.
// Depends on pps_pkg.
`default_nettype none

module pps_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pps_pkg::cmd_t       cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output pps_pkg::res_t       res
);
	import pps_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} state_t;

	state_t             state_q, state_d;
	logic               run_valid_q, run_valid_d;
	logic [PID_W-1:0]   run_pid_q, run_pid_d;
	logic [LVL_W-1:0]   run_lvl_q, run_lvl_d;
	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   head_d [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [PTR_W-1:0]   tail_d [LEVELS];
	logic [CNT_W-1:0]   cnt_q  [LEVELS];
	logic [CNT_W-1:0]   cnt_d  [LEVELS];
	logic               out_valid_q, out_valid_d;
	res_t               out_res_q, out_res_d;

	logic [PID_W-1:0]   mem_q [LEVELS * QUEUE_DEPTH];
	logic [PID_W-1:0]   rd_data_q;
	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [PID_W-1:0]   wr_pid;

	logic               out_free;
	logic               any_ready;
	logic [LVL_W-1:0]   hi_lvl;
	logic               enq_req;
	logic [LVL_W-1:0]   enq_lvl;
	logic [PID_W-1:0]   enq_pid;
	logic               emit;
	status_t            stat;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
	                                                input logic [PTR_W-1:0] ptr);
		slot_addr = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_res_q;

	// Highest non-empty level
	always_comb begin
		any_ready = 1'b0;
		hi_lvl    = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (cnt_q[l] != '0) begin
				any_ready = 1'b1;
				hi_lvl    = LVL_W'(l);
			end
		end
	end

	// Command decision
	always_comb begin
		state_d     = state_q;
		run_valid_d = run_valid_q;
		run_pid_d   = run_pid_q;
		run_lvl_d   = run_lvl_q;
		head_d      = head_q;
		tail_d      = tail_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !res_ready;
		out_res_d   = out_res_q;
		cmd_ready   = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_pid      = '0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		enq_req     = 1'b0;
		enq_lvl     = '0;
		enq_pid     = '0;
		emit        = 1'b0;
		stat        = STAT_OK;

		unique case (state_q)
			S_IDLE: begin
				cmd_ready = out_free;
				if (cmd_valid && out_free) begin
					emit = 1'b1;
					if (!cmd.release_cpu) begin
						if (!run_valid_q) begin
							run_valid_d = 1'b1;
							run_pid_d   = cmd.pid;
							run_lvl_d   = cmd.level;
						end else if (cmd.level > run_lvl_q) begin
							// preempt: old runner back to its queue tail
							enq_req   = 1'b1;
							enq_lvl   = run_lvl_q;
							enq_pid   = run_pid_q;
							run_pid_d = cmd.pid;
							run_lvl_d = cmd.level;
						end else begin
							enq_req = 1'b1;
							enq_lvl = cmd.level;
							enq_pid = cmd.pid;
						end
					end else if (!run_valid_q) begin
						stat = STAT_IDLE_REL;
					end else if (any_ready) begin
						// dispatch head of top queue; pid arrives next cycle
						rd_en           = 1'b1;
						rd_addr         = slot_addr(hi_lvl, head_q[hi_lvl]);
						head_d[hi_lvl]  = ptr_inc(head_q[hi_lvl]);
						cnt_d[hi_lvl]   = cnt_q[hi_lvl] - 1'b1;
						run_lvl_d       = hi_lvl;
						state_d         = S_FETCH;
						emit            = 1'b0;
					end else begin
						run_valid_d = 1'b0;
						run_pid_d   = '0;
						run_lvl_d   = '0;
					end

					// tail append, or drop when full
					if (enq_req) begin
						if (cnt_q[enq_lvl] == CNT_W'(QUEUE_DEPTH)) begin
							stat = STAT_FULL;
						end else begin
							wr_en           = 1'b1;
							wr_addr         = slot_addr(enq_lvl, tail_q[enq_lvl]);
							wr_pid          = enq_pid;
							tail_d[enq_lvl] = ptr_inc(tail_q[enq_lvl]);
							cnt_d[enq_lvl]  = cnt_q[enq_lvl] + 1'b1;
						end
					end

					if (emit) begin
						out_valid_d                  = 1'b1;
						out_res_d.cpu_busy           = run_valid_d;
						out_res_d.running_pid        = run_valid_d ? PID_PORT_W'(run_pid_d) : '0;
						out_res_d.running_priority   =
							run_valid_d ? PRIO_PORT_W'(run_lvl_d) : '0;
						out_res_d.status             = stat;
					end
				end
			end
			S_FETCH: begin
				if (out_free) begin
					run_valid_d                = 1'b1;
					run_pid_d                  = rd_data_q;
					out_valid_d                = 1'b1;
					out_res_d.cpu_busy         = 1'b1;
					out_res_d.running_pid      = PID_PORT_W'(rd_data_q);
					out_res_d.running_priority = PRIO_PORT_W'(run_lvl_q);
					out_res_d.status           = STAT_OK;
					state_d                    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, queue pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_valid_q <= 1'b0;
			run_pid_q   <= '0;
			run_lvl_q   <= '0;
			out_valid_q <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			state_q     <= state_d;
			run_valid_q <= run_valid_d;
			run_pid_q   <= run_pid_d;
			run_lvl_q   <= run_lvl_d;
			out_valid_q <= out_valid_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			cnt_q       <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		out_res_q <= out_res_d;
	end

	// Ready-queue memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_pid;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ src/pps_checker.sv @@
// Port-level checks for the preemptive priority scheduler, bound to its top level.
// Depends on pps_pkg and preemptive_priority_scheduler_unit.
`default_nettype none

module pps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [pps_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [0:0]                    s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import pps_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed under stall");

	// Idle CPU reports zero pid and priority
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[11:1] == 11'd0)
		else $error("idle result carries pid or priority");

	// Release while idle leaves the CPU idle
	a_idle_rel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[13:12] == 2'(STAT_IDLE_REL) |-> !m_axis_tdata[0])
		else $error("idle release reported busy CPU");

	// Running priority within configured levels, padding clear
	a_prio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(m_axis_tdata[11:9]) <= LEVELS - 1
			&& m_axis_tdata[15:14] == 2'b00)
		else $error("running priority out of range");

	// Status code never unused value
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[13:12] != 2'd3)
		else $error("undefined status code");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
